@@ sv/upd_pkg.sv @@
// shared types, constants and helper functions for the url path decoder
// no dependencies; imported by every module of the block

package upd_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LC_A    = 8'h61;
    localparam logic [7:0] CH_LC_F    = 8'h66;
    localparam logic [7:0] CH_UC_A    = 8'h41;
    localparam logic [7:0] CH_UC_F    = 8'h46;

    localparam logic [3:0] SFX_LAST = 4'd9;

    typedef enum logic [2:0] {
        ESC_NONE = 3'b001,
        ESC_HI   = 3'b010,
        ESC_LO   = 3'b100
    } t_esc_phase;

    // one queued result; suffix asks the back end to append "index.html"
    typedef struct packed {
        logic [7:0] data;
        logic       status;
        logic       last;
        logic       suffix;
    } t_cmd;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } t_hex;

    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex r;
        r.ok  = 1'b1;
        r.nib = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            r.nib = 4'(c - CH_ZERO);
        end else if (c >= CH_LC_A && c <= CH_LC_F) begin
            r.nib = 4'(c - CH_LC_A + 8'd10);
        end else if (c >= CH_UC_A && c <= CH_UC_F) begin
            r.nib = 4'(c - CH_UC_A + 8'd10);
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    // "index.html"
    function automatic logic [7:0] suffix_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h69;
            4'd1:    c = 8'h6E;
            4'd2:    c = 8'h64;
            4'd3:    c = 8'h65;
            4'd4:    c = 8'h78;
            4'd5:    c = 8'h2E;
            4'd6:    c = 8'h68;
            4'd7:    c = 8'h74;
            4'd8:    c = 8'h6D;
            default: c = 8'h6C;
        endcase
        return c;
    endfunction

endpackage

@@ sv/upd_front.sv @@
// front end: percent decoding, path checks and error discard per request byte
// depends on upd_pkg; feeds upd_queue with one command per result

module upd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [7:0]    i_data_byte,
    input  logic          i_end_of_target,
    input  logic          i_full,
    output logic          o_in_stall,
    output logic          o_push,
    output upd_pkg::t_cmd o_cmd
);
    import upd_pkg::*;

    t_esc_phase r_phase, n_phase;
    logic [3:0] r_hi, n_hi;
    logic       r_prev_dot, n_prev_dot;
    logic       r_started, n_started;
    logic       r_discard, n_discard;

    logic       acc;
    logic       emit;
    logic       fail;
    logic [7:0] dec;
    logic       do_push;
    t_cmd       cmd;
    t_hex       hx;

    assign acc        = i_in_valid && !i_full;
    assign o_in_stall = i_full;
    assign hx         = hex_value(i_data_byte);

    always_comb begin
        n_phase    = r_phase;
        n_hi       = r_hi;
        n_prev_dot = r_prev_dot;
        n_started  = r_started;
        n_discard  = r_discard;
        emit       = 1'b0;
        fail       = 1'b0;
        dec        = i_data_byte;
        do_push    = 1'b0;
        cmd        = '0;

        if (r_discard) begin
            if (i_end_of_target) begin
                n_discard = 1'b0;
            end
        end else begin
            case (r_phase)
                ESC_HI: begin
                    if (!hx.ok || i_end_of_target) begin
                        fail = 1'b1;
                    end else begin
                        n_hi    = hx.nib;
                        n_phase = ESC_LO;
                    end
                end
                ESC_LO: begin
                    n_phase = ESC_NONE;
                    if (!hx.ok) begin
                        fail = 1'b1;
                    end else begin
                        dec  = {r_hi, hx.nib};
                        emit = 1'b1;
                    end
                end
                default: begin
                    n_phase = ESC_NONE;
                    if (i_data_byte == CH_PERCENT) begin
                        if (i_end_of_target) begin
                            fail = 1'b1;
                        end else begin
                            n_phase = ESC_HI;
                        end
                    end else begin
                        dec  = (i_data_byte == CH_PLUS) ? CH_SPACE : i_data_byte;
                        emit = 1'b1;
                    end
                end
            endcase

            // path checks on the decoded byte
            if (emit) begin
                if ((!r_started && dec != CH_SLASH) || (dec == CH_DOT && r_prev_dot)) begin
                    fail = 1'b1;
                end else begin
                    n_started  = 1'b1;
                    n_prev_dot = (dec == CH_DOT);
                    do_push    = 1'b1;
                    cmd.data   = dec;
                    cmd.status = 1'b0;
                    cmd.suffix = i_end_of_target && (dec == CH_SLASH);
                    cmd.last   = i_end_of_target && (dec != CH_SLASH);
                    if (i_end_of_target) begin
                        n_phase    = ESC_NONE;
                        n_hi       = 4'd0;
                        n_prev_dot = 1'b0;
                        n_started  = 1'b0;
                    end
                end
            end

            if (fail) begin
                do_push    = 1'b1;
                cmd.data   = 8'd0;
                cmd.status = 1'b1;
                cmd.last   = 1'b1;
                cmd.suffix = 1'b0;
                n_phase    = ESC_NONE;
                n_hi       = 4'd0;
                n_prev_dot = 1'b0;
                n_started  = 1'b0;
                n_discard  = !i_end_of_target;
            end
        end
    end

    assign o_push = acc && do_push;
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= ESC_NONE;
            r_hi       <= 4'd0;
            r_prev_dot <= 1'b0;
            r_started  <= 1'b0;
            r_discard  <= 1'b0;
        end else if (acc) begin
            r_phase    <= n_phase;
            r_hi       <= n_hi;
            r_prev_dot <= n_prev_dot;
            r_started  <= n_started;
            r_discard  <= n_discard;
        end
    end

endmodule

@@ sv/upd_queue.sv @@
// short command queue between front and back end
// depends on upd_pkg for the command type

module upd_queue #(
    parameter int DEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  upd_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output upd_pkg::t_cmd o_head,
    output logic          o_empty,
    output logic          o_full
);
    import upd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_MAX);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_MAX) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_MAX) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count lost a push");

endmodule

@@ sv/upd_back.sv @@
// back end: drains queued commands into the output register, expands index suffix
// depends on upd_pkg for the command type and suffix table

module upd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  upd_pkg::t_cmd i_head,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [7:0]    o_out_byte,
    output logic          o_status,
    output logic          o_last_of_path
);
    import upd_pkg::*;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_status;
    logic       r_out_last;
    logic       r_sfx_active;
    logic [3:0] r_sfx_cnt;

    logic load;
    logic take_head;
    logic sfx_done;

    assign load      = !r_out_valid || !i_out_stall;
    assign take_head = load && !r_sfx_active && !i_empty;
    assign sfx_done  = load && r_sfx_active && (r_sfx_cnt == SFX_LAST);
    // the '/' command stays at the head until its suffix is out
    assign o_pop     = sfx_done || (take_head && !i_head.suffix);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_sfx_active <= 1'b0;
            r_sfx_cnt    <= 4'd0;
        end else if (load) begin
            if (r_sfx_active) begin
                r_out_valid  <= 1'b1;
                r_sfx_cnt    <= r_sfx_cnt + 4'd1;
                r_sfx_active <= !sfx_done;
            end else if (!i_empty) begin
                r_out_valid  <= 1'b1;
                r_sfx_active <= i_head.suffix;
                r_sfx_cnt    <= 4'd0;
            end else begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_sfx_active) begin
                r_out_byte   <= suffix_char(r_sfx_cnt);
                r_out_status <= 1'b0;
                r_out_last   <= (r_sfx_cnt == SFX_LAST);
            end else begin
                r_out_byte   <= i_head.data;
                r_out_status <= i_head.status;
                r_out_last   <= i_head.last;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_status       = r_out_status;
    assign o_last_of_path = r_out_last;

    a_sfx_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sfx_active |-> !i_empty)
        else $error("suffix expansion without its command");

    a_sfx_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sfx_active |-> (r_sfx_cnt <= SFX_LAST))
        else $error("suffix counter out of range");

    a_sfx_ends_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sfx_done |=> (r_out_valid && r_out_last && !r_sfx_active))
        else $error("suffix did not end the path");

endmodule

@@ sv/upd_top_placeholder_unused.sv @@
// holds no logic; the block's top level is url_path_decode_check_core
// no dependencies

@@ sv/url_path_decode_check_core.sv @@
// top level of the url path decoder and checker
// depends on upd_pkg, upd_front, upd_queue, upd_back
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_stall     | i_data_byte, i_end_of_target
//  out     | output    | o_out_valid / i_out_stall   | o_out_byte, o_status, o_last_of_path
//
//  one request byte is taken per cycle while the queue is not full; a result passes through
//  the command queue and then the output register, and output stall can hold it in between
//  a path ending in '/' drains as 11 results from the back end, one per cycle while the output is not stalled;
//  the front keeps accepting until the QUEUE_DEPTH-entry command queue fills
//  reset is synchronous, active low, and clears decoder state, queue and output valid
//  input stall follows only the queue-full flag, never the output stall directly

module url_path_decode_check_core #(
    parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_target,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_status,
    output logic       o_last_of_path
);
    import upd_pkg::*;

    // front to queue
    logic push;
    t_cmd push_cmd;
    logic q_full;

    // queue to back
    t_cmd head;
    logic q_empty;
    logic pop;

    // decoder: escape phases, leading slash and double dot checks, error discard
    upd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_data_byte     (i_data_byte),
        .i_end_of_target (i_end_of_target),
        .i_full          (q_full),
        .o_in_stall      (o_in_stall),
        .o_push          (push),
        .o_cmd           (push_cmd)
    );

    // command queue decouples decode from output back-pressure
    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // back end: output register plus "index.html" expansion
    upd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_empty        (q_empty),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_status       (o_status),
        .o_last_of_path (o_last_of_path)
    );

endmodule

@@ tb/upd_path_checker.sv @@
`timescale 1ns / 100ps
// watches both channels of the url path decoder, predicts decoded path bytes
// depends on upd_pkg; instantiated beside the block by the testbench top

module upd_path_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_target,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_out_byte,
    input  logic       i_status,
    input  logic       i_last_of_path,
    output int         o_fail_count,
    output int         o_pending
);
    import upd_pkg::*;

    localparam string INDEX_PAGE = "index.html";

    typedef struct packed {
        logic [7:0] data;
        logic       bad;
        logic       last;
    } t_path_result;

    t_path_result expected_path[$];

    // decoder state as the block should hold it
    t_esc_phase phase     = ESC_NONE;
    logic [3:0] hi_nib    = 4'd0;
    logic       prev_dot  = 1'b0;
    logic       started   = 1'b0;
    logic       dropping  = 1'b0;

    // {is hex, value}
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            return {1'b1, c[3:0]};
        end
        if ((c >= CH_LC_A && c <= CH_LC_F) || (c >= CH_UC_A && c <= CH_UC_F)) begin
            return {1'b1, c[3:0] + 4'd9};
        end
        return 5'd0;
    endfunction

    task automatic push_result(input logic [7:0] d, input logic bad, input logic last);
        expected_path.push_back(t_path_result'{d, bad, last});
    endtask

    task automatic clear_request();
        phase    = ESC_NONE;
        hi_nib   = 4'd0;
        prev_dot = 1'b0;
        started  = 1'b0;
        dropping = 1'b0;
    endtask

    // bad request: one error result, then skip the rest unless this was the last byte
    task automatic reject(input logic eot);
        push_result(8'd0, 1'b1, 1'b1);
        clear_request();
        dropping = !eot;
    endtask

    task automatic accept_decoded(input logic [7:0] d, input logic eot);
        if ((!started && d != CH_SLASH) || (d == CH_DOT && prev_dot)) begin
            reject(eot);
        end else begin
            started  = 1'b1;
            prev_dot = (d == CH_DOT);
            if (eot && d == CH_SLASH) begin
                push_result(d, 1'b0, 1'b0);
                for (int i = 0; i < 10; i++) begin
                    push_result(INDEX_PAGE[i], 1'b0, i == 9);
                end
            end else begin
                push_result(d, 1'b0, eot);
            end
            if (eot) begin
                clear_request();
            end
        end
    endtask

    task automatic take_byte(input logic [7:0] raw, input logic eot);
        logic [4:0] dig;
        dig = digit_of(raw);
        if (dropping) begin
            if (eot) begin
                clear_request();
            end
        end else if (phase == ESC_HI) begin
            if (!dig[4] || eot) begin
                reject(eot);
            end else begin
                hi_nib = dig[3:0];
                phase  = ESC_LO;
            end
        end else if (phase == ESC_LO) begin
            if (!dig[4]) begin
                reject(eot);
            end else begin
                phase = ESC_NONE;
                accept_decoded({hi_nib, dig[3:0]}, eot);
            end
        end else if (raw == CH_PERCENT) begin
            if (eot) begin
                reject(eot);
            end else begin
                phase = ESC_HI;
            end
        end else begin
            accept_decoded((raw == CH_PLUS) ? CH_SPACE : raw, eot);
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_path_result want;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_path.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (o_fail_count <= 10) begin
                        $display("%0t unexpected result: byte %02h status %0d last %0d",
                                 $realtime, i_out_byte, i_status, i_last_of_path);
                    end
                end else begin
                    want = expected_path.pop_front();
                    if (want.data != i_out_byte || want.bad != i_status
                            || want.last != i_last_of_path) begin
                        o_fail_count = o_fail_count + 1;
                        if (o_fail_count <= 10) begin
                            // byte/status/last
                            $display("%0t mismatch: expected %02h/%0d/%0d, got %02h/%0d/%0d",
                                     $realtime, want.data, want.bad, want.last,
                                     i_out_byte, i_status, i_last_of_path);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                take_byte(i_data_byte, i_end_of_target);
            end
        end
        o_pending = expected_path.size();
    end

endmodule

@@ tb/url_path_decode_check_core_test.sv @@
`timescale 1ns / 100ps
// testbench top for url_path_decode_check_core: drives request bytes and output stall
// depends on upd_pkg, the block and upd_path_checker

module url_path_decode_check_core_test;
    import upd_pkg::*;

    // generous cycle budget, far above the slowest legal run
    localparam int CYCLE_LIMIT = 200000;
    // total request bytes to send, directed part included
    localparam int ITEM_GOAL   = 250;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_data_byte = 8'd0;
    logic       i_end_of_target = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_status;
    logic       o_last_of_path;

    int         fail_count;
    int         pending;
    int         items_sent = 0;
    int         cycle_count = 0;
    // when set, neither side idles
    logic       quiet = 1'b0;
    // bytes of the request target being sent
    logic [7:0] target_bytes[$];

    url_path_decode_check_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_end_of_target(i_end_of_target),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_status       (o_status),
        .o_last_of_path (o_last_of_path)
    );

    upd_path_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_end_of_target(i_end_of_target),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out_byte     (o_out_byte),
        .i_status       (o_status),
        .i_last_of_path (o_last_of_path),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watchdog in case the block hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // output side stalls at random with a 37 percent chance unless in the quiet stretch
    always @(negedge i_clk) begin
        i_out_stall = !quiet && ($urandom_range(99) < 37);
    end

    // one request byte: random idle cycles first, then hold until accepted
    task automatic send_item(input logic [7:0] b, input logic eot);
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < 37) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      = 1'b1;
        i_data_byte     = b;
        i_end_of_target = eot;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    // whole request target, end marker on its last byte
    task automatic send_target();
        foreach (target_bytes[i]) begin
            send_item(target_bytes[i], i == target_bytes.size() - 1);
        end
    endtask

    task automatic send_text(input string s);
        target_bytes = {};
        for (int i = 0; i < s.len(); i++) begin
            target_bytes.push_back(s[i]);
        end
        send_target();
    endtask

    // hex digit for a nibble, letters in either case at random
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) begin
            return CH_ZERO + 8'(n);
        end
        return ($urandom_range(1) ? CH_LC_A : CH_UC_A) + 8'(n) - 8'd10;
    endfunction

    task automatic push_escape(input logic [7:0] v);
        target_bytes.push_back(CH_PERCENT);
        target_bytes.push_back(hex_char(v[7:4]));
        target_bytes.push_back(hex_char(v[3:0]));
    endtask

    // mostly well-formed paths with random content, some broken ones, some noise
    task automatic make_target();
        int kind;
        int pieces;
        target_bytes = {};
        kind = $urandom_range(99);
        if (kind < 15) begin
            // raw noise
            repeat ($urandom_range(1, 6)) begin
                target_bytes.push_back(8'($urandom_range(255)));
            end
        end else begin
            // leading slash, sometimes as an escape
            if ($urandom_range(7) == 0) begin
                push_escape(CH_SLASH);
            end else begin
                target_bytes.push_back(CH_SLASH);
            end
            pieces = $urandom_range(0, 8);
            repeat (pieces) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: target_bytes.push_back(CH_LC_A + 8'($urandom_range(25)));
                    4:          target_bytes.push_back(CH_SLASH);
                    5:          target_bytes.push_back(CH_DOT);
                    6:          target_bytes.push_back(CH_PLUS);
                    7, 8:       push_escape(8'($urandom_range(255)));
                    default:    target_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
                endcase
            end
            if ($urandom_range(3) == 0) begin
                target_bytes.push_back(CH_SLASH);
            end
            if (kind < 27) begin
                // broken escape: cut off, or a non-hex digit inside
                target_bytes.push_back(CH_PERCENT);
                case ($urandom_range(2))
                    0: ;
                    1: target_bytes.push_back(hex_char(4'($urandom_range(15))));
                    default: begin
                        target_bytes.push_back(8'h67 + 8'($urandom_range(10)));
                        target_bytes.push_back(CH_LC_A + 8'($urandom_range(25)));
                    end
                endcase
            end
        end
    endtask

    initial begin
        // reset held low, then released
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: lone slash gets the index suffix
        send_text("/");
        // bad first byte on the last byte of the request
        target_bytes = {8'hFF};
        send_target();
        // plus becomes space, lowercase hex escape
        send_text("/+%7e");
        // escaped slash in upper case, ends the path so suffix follows
        send_text("%2F");
        // two dots in a row mid request, then the tail is dropped
        target_bytes = {CH_SLASH, CH_DOT, CH_DOT, 8'hFF, 8'h00};
        send_target();
        // escape cut off right after the percent sign
        send_text("/%");
        // escape cut off after the first digit
        send_text("/%4");
        // non-hex digit inside an escape, rest of the request dropped
        send_text("/%G0");

        // hold off until every expected result has come back
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end

        // random part, with a stretch where neither side idles
        while (items_sent < ITEM_GOAL) begin
            quiet = (items_sent >= 120 && items_sent < 170);
            make_target();
            send_target();
        end
        quiet = 1'b0;

        // drain, then keep watching for stray results before the verdict
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (20) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/upd_pkg.sv
sv/upd_front.sv
sv/upd_queue.sv
sv/upd_back.sv
sv/upd_top_placeholder_unused.sv
sv/url_path_decode_check_core.sv
tb/upd_path_checker.sv
tb/url_path_decode_check_core_test.sv
